// ----- hdl/pcpc_pkg.sv -----
// shared types and constants for the point camera projection cull block
`default_nettype none
package pcpc_pkg;

    // fixed field widths
    localparam int unsigned COORD_W = 32;
    localparam int unsigned COEF_W  = 32;
    localparam int unsigned PROD_W  = 64;
    localparam int unsigned SUM_W   = 66;
    // row sums kept wide enough for the smallest fraction width
    localparam int unsigned ROW_W   = 58;
    localparam int unsigned MAG_W   = ROW_W - 1;
    localparam int unsigned PIX_W   = 32;
    localparam int unsigned DIV_W   = MAG_W + PIX_W;
    localparam int unsigned DIM_W   = 16;
    localparam int unsigned BND_W   = DIM_W + MAG_W;
    localparam int unsigned IDX_W   = 17;
    localparam int unsigned CFG_W   = 64;
    localparam int unsigned CFG_A_W = 3;

    // parameter defaults
    localparam int unsigned MAX_POINTS_DEF = 131072;
    localparam int unsigned FRAC_BITS_DEF  = 16;

    // configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        REG_ROW0_01,
        REG_ROW0_23,
        REG_ROW1_01,
        REG_ROW1_23,
        REG_ROW2_01,
        REG_ROW2_23,
        REG_WIDTH,
        REG_HEIGHT
    } cfg_reg_t;

    // fields that ride alongside the arithmetic
    typedef struct packed {
        logic [IDX_W-1:0]          index;
        logic signed [COORD_W-1:0] depth;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sz;
        logic                      last;
        logic                      vis;
        logic                      zero_u;
        logic                      zero_v;
        logic                      ovf_u;
        logic                      ovf_v;
    } side_t;

    // word handed from one divider cell to the next
    typedef struct packed {
        logic [DIV_W-1:0] rem_u;
        logic [DIV_W-1:0] rem_v;
        logic [PIX_W-1:0] q_u;
        logic [PIX_W-1:0] q_v;
        logic [MAG_W-1:0] den;
        side_t            side;
    } cell_t;

endpackage
`default_nettype wire

// ----- hdl/pcpc_row_mac.sv -----
// one projection row: three products, then exact sum floored to the fraction width
`default_nettype none
module pcpc_row_mac #(
    parameter int unsigned FRAC_BITS = pcpc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic [pcpc_pkg::CFG_W-1:0]           cols01,
    input  wire logic [pcpc_pkg::CFG_W-1:0]           cols23,
    input  wire logic signed [pcpc_pkg::COORD_W-1:0]  x,
    input  wire logic signed [pcpc_pkg::COORD_W-1:0]  y,
    input  wire logic signed [pcpc_pkg::COORD_W-1:0]  z,
    output logic signed [pcpc_pkg::ROW_W-1:0]         row_sum
);
    logic signed [pcpc_pkg::PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [pcpc_pkg::COEF_W-1:0] c3_reg;
    logic signed [pcpc_pkg::ROW_W-1:0]  row_reg;
    logic signed [pcpc_pkg::SUM_W-1:0]  sum_next;
    logic signed [pcpc_pkg::SUM_W-1:0]  c3_term;
    logic signed [pcpc_pkg::SUM_W-1:0]  shifted;

    // products stage
    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg <= $signed(cols01[31:0]) * x;
            p1_reg <= $signed(cols01[63:32]) * y;
            p2_reg <= $signed(cols23[31:0]) * z;
            c3_reg <= $signed(cols23[63:32]);
        end
    end

    // exact sum, floor by arithmetic shift
    always_comb begin
        c3_term  = $signed({{(pcpc_pkg::SUM_W-pcpc_pkg::COEF_W){c3_reg[31]}}, c3_reg})
                   <<< FRAC_BITS;
        sum_next = $signed({{2{p0_reg[63]}}, p0_reg}) + $signed({{2{p1_reg[63]}}, p1_reg})
                 + $signed({{2{p2_reg[63]}}, p2_reg}) + c3_term;
        shifted  = sum_next >>> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row_reg <= shifted[pcpc_pkg::ROW_W-1:0];
        end
    end

    assign row_sum = row_reg;

endmodule
`default_nettype wire

// ----- hdl/pcpc_div_cell.sv -----
// one restoring divide cell: settles one quotient bit for both pixel lanes
`default_nettype none
module pcpc_div_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire pcpc_pkg::cell_t in_word,
    output logic                 out_valid,
    output pcpc_pkg::cell_t      out_word
);
    logic            valid_reg;
    pcpc_pkg::cell_t word_reg;
    pcpc_pkg::cell_t word_next;
    logic [pcpc_pkg::DIV_W-1:0] sub;

    // trial subtract of the shifted divisor on each lane
    always_comb begin
        word_next = in_word;
        sub = {{pcpc_pkg::PIX_W{1'b0}}, in_word.den} << SHIFT;
        if (in_word.rem_u >= sub) begin
            word_next.rem_u      = in_word.rem_u - sub;
            word_next.q_u[SHIFT] = 1'b1;
        end
        if (in_word.rem_v >= sub) begin
            word_next.rem_v      = in_word.rem_v - sub;
            word_next.q_v[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

// ----- hdl/point_camera_projection_cull.sv -----
// top level: projects lidar points through a 3x4 matrix and culls against the image
//
// Usage: points enter on the s_ channel (valid/ready), one word per clock if ready.
// Each point yields exactly one result word on the m_ channel, in order.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wr_data);
// write it only while no point is in flight.
// Pipeline: row products, row sums, divisor prep and bound compare, the 32
// cells of the divide chain (one quotient bit each), one output register.
// Throughput: one point per clock while the output is not stalled; the
// whole chain moves together, so the sustained rate is set by the divide
// cell chain advancing once per cycle.
// Stall: when m_ready is low with a result waiting, every stage holds and
// s_ready drops in the same cycle; nothing is lost.
// Reset (aresetn low, synchronous): all stage valid bits and the point
// counter clear, the matrix clears to zero and the image size returns to
// 640 by 480.
`default_nettype none
module point_camera_projection_cull #(
    parameter int unsigned MAX_POINTS = pcpc_pkg::MAX_POINTS_DEF,
    parameter int unsigned FRAC_BITS  = pcpc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [pcpc_pkg::CFG_A_W-1:0]        cfg_index,
    input  wire logic [pcpc_pkg::CFG_W-1:0]          cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [pcpc_pkg::COORD_W-1:0] s_point_x,
    input  wire logic signed [pcpc_pkg::COORD_W-1:0] s_point_y,
    input  wire logic signed [pcpc_pkg::COORD_W-1:0] s_point_z,
    input  wire logic                                s_last_point,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_visible,
    output logic [pcpc_pkg::IDX_W-1:0]               m_point_index,
    output logic [pcpc_pkg::PIX_W-1:0]               m_pixel_u,
    output logic [pcpc_pkg::PIX_W-1:0]               m_pixel_v,
    output logic signed [pcpc_pkg::COORD_W-1:0]      m_depth,
    output logic signed [pcpc_pkg::COORD_W-1:0]      m_source_x,
    output logic signed [pcpc_pkg::COORD_W-1:0]      m_source_y,
    output logic signed [pcpc_pkg::COORD_W-1:0]      m_source_z,
    output logic                                     m_end_of_cloud
);
    localparam int unsigned NCELL = pcpc_pkg::PIX_W;
    localparam int unsigned CAP_I = (MAX_POINTS - 1 > 131071) ? 131071 : MAX_POINTS - 1;
    localparam logic [pcpc_pkg::IDX_W-1:0] CAP = pcpc_pkg::IDX_W'(CAP_I);

    localparam logic signed [pcpc_pkg::ROW_W-1:0] DEPTH_MAX =
        pcpc_pkg::ROW_W'(64'sh7FFF_FFFF);
    localparam logic signed [pcpc_pkg::ROW_W-1:0] DEPTH_MIN =
        -pcpc_pkg::ROW_W'(64'sh8000_0000);

    logic [pcpc_pkg::CFG_W-1:0] r0a_reg, r0b_reg, r1a_reg, r1b_reg, r2a_reg, r2b_reg;
    logic [pcpc_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [pcpc_pkg::IDX_W-1:0] cnt_reg, cnt_next;

    logic en, in_acc;
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    pcpc_pkg::side_t s1_side_next;
    pcpc_pkg::side_t s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg;

    logic signed [pcpc_pkg::ROW_W-1:0] px, py, pw;

    // stage 3 and 4 payload
    logic [pcpc_pkg::DIV_W-1:0] s3_nu_reg, s3_nv_reg, s4_nu_reg, s4_nv_reg;
    logic [pcpc_pkg::MAG_W-1:0] s3_w_reg, s4_w_reg;
    logic [pcpc_pkg::MAG_W-1:0] s3_mu_reg, s3_mv_reg;
    logic [pcpc_pkg::BND_W-1:0] s3_bu_reg, s3_bv_reg;
    pcpc_pkg::side_t s3_side_next, s4_side_next;

    logic            cv [NCELL+1];
    pcpc_pkg::cell_t cw [NCELL+1];

    logic out_v_reg;
    pcpc_pkg::side_t out_side_reg;
    logic [pcpc_pkg::PIX_W-1:0] out_u_reg, out_v_pix_reg;

    // whole chain advances unless a result is stuck at the output
    assign en      = m_ready || !out_v_reg;
    assign s_ready = en;
    assign in_acc  = s_valid && en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0a_reg    <= '0;
            r0b_reg    <= '0;
            r1a_reg    <= '0;
            r1b_reg    <= '0;
            r2a_reg    <= '0;
            r2b_reg    <= '0;
            width_reg  <= 16'd640;
            height_reg <= 16'd480;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pcpc_pkg::REG_ROW0_01: r0a_reg    <= cfg_wr_data;
                pcpc_pkg::REG_ROW0_23: r0b_reg    <= cfg_wr_data;
                pcpc_pkg::REG_ROW1_01: r1a_reg    <= cfg_wr_data;
                pcpc_pkg::REG_ROW1_23: r1b_reg    <= cfg_wr_data;
                pcpc_pkg::REG_ROW2_01: r2a_reg    <= cfg_wr_data;
                pcpc_pkg::REG_ROW2_23: r2b_reg    <= cfg_wr_data;
                pcpc_pkg::REG_WIDTH:   width_reg  <= cfg_wr_data[pcpc_pkg::DIM_W-1:0];
                pcpc_pkg::REG_HEIGHT:  height_reg <= cfg_wr_data[pcpc_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // point counter, cleared after the last point of a cloud
    always_comb begin
        if (s_last_point) begin
            cnt_next = '0;
        end else if (cnt_reg < CAP) begin
            cnt_next = cnt_reg + 1'b1;
        end else begin
            cnt_next = CAP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (in_acc) begin
            cnt_reg <= cnt_next;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= s_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    // row dot products
    pcpc_row_mac #(.FRAC_BITS(FRAC_BITS)) u_row0 (
        .aclk(aclk), .en(en), .cols01(r0a_reg), .cols23(r0b_reg),
        .x(s_point_x), .y(s_point_y), .z(s_point_z), .row_sum(px)
    );
    pcpc_row_mac #(.FRAC_BITS(FRAC_BITS)) u_row1 (
        .aclk(aclk), .en(en), .cols01(r1a_reg), .cols23(r1b_reg),
        .x(s_point_x), .y(s_point_y), .z(s_point_z), .row_sum(py)
    );
    pcpc_row_mac #(.FRAC_BITS(FRAC_BITS)) u_row2 (
        .aclk(aclk), .en(en), .cols01(r2a_reg), .cols23(r2b_reg),
        .x(s_point_x), .y(s_point_y), .z(s_point_z), .row_sum(pw)
    );

    // side fields of the incoming word
    always_comb begin
        s1_side_next       = '0;
        s1_side_next.index = cnt_reg;
        s1_side_next.sx    = s_point_x;
        s1_side_next.sy    = s_point_y;
        s1_side_next.sz    = s_point_z;
        s1_side_next.last  = s_last_point;
    end

    // side fields ride beside the row sums
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg <= s1_side_next;
            s2_side_reg <= s1_side_reg;
        end
    end

    // prep: sign checks, depth clamp, scaled numerators, bound products
    always_comb begin
        s3_side_next = s2_side_reg;
        if (pw > DEPTH_MAX) begin
            s3_side_next.depth = 32'sh7FFF_FFFF;
        end else if (pw < DEPTH_MIN) begin
            s3_side_next.depth = 32'sh8000_0000;
        end else begin
            s3_side_next.depth = pw[pcpc_pkg::COORD_W-1:0];
        end
        s3_side_next.zero_u = (pw <= 0) || px[pcpc_pkg::ROW_W-1];
        s3_side_next.zero_v = (pw <= 0) || py[pcpc_pkg::ROW_W-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_side_reg <= s3_side_next;
            s3_nu_reg   <= {{pcpc_pkg::PIX_W{1'b0}}, px[pcpc_pkg::MAG_W-1:0]} << FRAC_BITS;
            s3_nv_reg   <= {{pcpc_pkg::PIX_W{1'b0}}, py[pcpc_pkg::MAG_W-1:0]} << FRAC_BITS;
            s3_mu_reg   <= px[pcpc_pkg::MAG_W-1:0];
            s3_mv_reg   <= py[pcpc_pkg::MAG_W-1:0];
            s3_w_reg    <= pw[pcpc_pkg::MAG_W-1:0];
            s3_bu_reg   <= width_reg * pw[pcpc_pkg::MAG_W-1:0];
            s3_bv_reg   <= height_reg * pw[pcpc_pkg::MAG_W-1:0];
        end
    end

    // visibility and quotient overflow
    always_comb begin
        s4_side_next       = s3_side_reg;
        s4_side_next.vis   = !s3_side_reg.zero_u && !s3_side_reg.zero_v
                           && ({{pcpc_pkg::DIM_W{1'b0}}, s3_mu_reg} < s3_bu_reg)
                           && ({{pcpc_pkg::DIM_W{1'b0}}, s3_mv_reg} < s3_bv_reg);
        s4_side_next.ovf_u = s3_nu_reg >= {s3_w_reg, {pcpc_pkg::PIX_W{1'b0}}};
        s4_side_next.ovf_v = s3_nv_reg >= {s3_w_reg, {pcpc_pkg::PIX_W{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_side_reg <= s4_side_next;
            s4_nu_reg   <= s3_nu_reg;
            s4_nv_reg   <= s3_nv_reg;
            s4_w_reg    <= s3_w_reg;
        end
    end

    // divide chain head
    always_comb begin
        cv[0]       = s4_v_reg;
        cw[0].rem_u = s4_nu_reg;
        cw[0].rem_v = s4_nv_reg;
        cw[0].q_u   = '0;
        cw[0].q_v   = '0;
        cw[0].den   = s4_w_reg;
        cw[0].side  = s4_side_reg;
    end

    // one cell per quotient bit, most significant first
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        pcpc_div_cell #(.SHIFT(NCELL - 1 - k)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(cv[k]), .in_word(cw[k]),
            .out_valid(cv[k+1]), .out_word(cw[k+1])
        );
    end

    // output register with pixel saturation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= cv[NCELL];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_side_reg <= cw[NCELL].side;
            if (cw[NCELL].side.zero_u) begin
                out_u_reg <= '0;
            end else if (cw[NCELL].side.ovf_u) begin
                out_u_reg <= '1;
            end else begin
                out_u_reg <= cw[NCELL].q_u;
            end
            if (cw[NCELL].side.zero_v) begin
                out_v_pix_reg <= '0;
            end else if (cw[NCELL].side.ovf_v) begin
                out_v_pix_reg <= '1;
            end else begin
                out_v_pix_reg <= cw[NCELL].q_v;
            end
        end
    end

    assign m_valid        = out_v_reg;
    assign m_visible      = out_side_reg.vis;
    assign m_point_index  = out_side_reg.index;
    assign m_pixel_u      = out_u_reg;
    assign m_pixel_v      = out_v_pix_reg;
    assign m_depth        = out_side_reg.depth;
    assign m_source_x     = out_side_reg.sx;
    assign m_source_y     = out_side_reg.sy;
    assign m_source_z     = out_side_reg.sz;
    assign m_end_of_cloud = out_side_reg.last;

    // checks
    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (m_ready || !m_valid))
        else $error("input ready does not follow output stall");

    a_visible_has_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_visible |-> m_depth > 0)
        else $error("visible result with non-positive depth");

    a_counter_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CAP)
        else $error("point counter above its cap");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_point |=> cnt_reg == '0)
        else $error("counter not cleared after last point");

endmodule
`default_nettype wire

// ----- bench/tb_point_camera_projection_cull.sv -----
// testbench for the point camera projection cull block: self-checking with its own predictor
`default_nettype none
module tb_point_camera_projection_cull;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CNT_CAP   = 131071;
    localparam int unsigned DRAIN_CYC = 60;
    localparam longint      LIMIT     = 200000;

    typedef struct {
        logic                                vis;
        logic [pcpc_pkg::IDX_W-1:0]          index;
        logic [pcpc_pkg::PIX_W-1:0]          u;
        logic [pcpc_pkg::PIX_W-1:0]          v;
        logic signed [pcpc_pkg::COORD_W-1:0] depth;
        logic signed [pcpc_pkg::COORD_W-1:0] sx;
        logic signed [pcpc_pkg::COORD_W-1:0] sy;
        logic signed [pcpc_pkg::COORD_W-1:0] sz;
        logic                                eoc;
    } proj_result_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_wr_en;
    logic [pcpc_pkg::CFG_A_W-1:0]        cfg_index;
    logic [pcpc_pkg::CFG_W-1:0]          cfg_wr_data;
    logic                                s_valid;
    logic                                s_ready;
    logic signed [pcpc_pkg::COORD_W-1:0] s_point_x;
    logic signed [pcpc_pkg::COORD_W-1:0] s_point_y;
    logic signed [pcpc_pkg::COORD_W-1:0] s_point_z;
    logic                                s_last_point;
    logic                                m_valid;
    logic                                m_ready;
    logic                                m_visible;
    logic [pcpc_pkg::IDX_W-1:0]          m_point_index;
    logic [pcpc_pkg::PIX_W-1:0]          m_pixel_u;
    logic [pcpc_pkg::PIX_W-1:0]          m_pixel_v;
    logic signed [pcpc_pkg::COORD_W-1:0] m_depth;
    logic signed [pcpc_pkg::COORD_W-1:0] m_source_x;
    logic signed [pcpc_pkg::COORD_W-1:0] m_source_y;
    logic signed [pcpc_pkg::COORD_W-1:0] m_source_z;
    logic                                m_end_of_cloud;

    point_camera_projection_cull u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .s_point_z      (s_point_z),
        .s_last_point   (s_last_point),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_visible      (m_visible),
        .m_point_index  (m_point_index),
        .m_pixel_u      (m_pixel_u),
        .m_pixel_v      (m_pixel_v),
        .m_depth        (m_depth),
        .m_source_x     (m_source_x),
        .m_source_y     (m_source_y),
        .m_source_z     (m_source_z),
        .m_end_of_cloud (m_end_of_cloud)
    );

    // clock, starting low so the first edge comes after time zero
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // shadow of the configuration and the point counter
    logic [pcpc_pkg::CFG_W-1:0] mat [6];
    logic [pcpc_pkg::DIM_W-1:0] img_w;
    logic [pcpc_pkg::DIM_W-1:0] img_h;
    logic [pcpc_pkg::IDX_W-1:0] pt_count;
    proj_result_t               proj_q [$];
    int                         errors;
    longint                     cycles;
    int                         burst_left;
    bit                         hold_req;

    // one row of the matrix times (x, y, z, 1), floored to the fraction width
    function automatic logic signed [65:0] row_sum(int r, logic signed [31:0] x,
                                                   logic signed [31:0] y,
                                                   logic signed [31:0] z);
        logic signed [31:0] c0, c1, c2, c3;
        logic signed [65:0] acc;
        c0 = mat[2*r][31:0];
        c1 = mat[2*r][63:32];
        c2 = mat[2*r+1][31:0];
        c3 = mat[2*r+1][63:32];
        acc = c0 * x + c1 * y + c2 * z + c3 * 66'sh10000;
        return acc >>> pcpc_pkg::FRAC_BITS_DEF;
    endfunction

    // pixel coordinate n/w with fraction bits, plus the bound test on the exact quotient
    function automatic logic [31:0] pixel_of(logic signed [65:0] n, logic signed [65:0] w,
                                             logic [15:0] bound, output bit in_range);
        logic [97:0] num, quo;
        logic [65:0] un, uw;
        if (n < 0) begin
            in_range = 0;
            return '0;
        end
        un = n;
        uw = w;
        in_range = (un / uw) < bound;
        num = {32'd0, un} << pcpc_pkg::FRAC_BITS_DEF;
        quo = num / {32'd0, uw};
        return (quo > 98'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    endfunction

    // expected result for one accepted point, advancing the counter
    function automatic proj_result_t project_point(logic signed [31:0] x, logic signed [31:0] y,
                                                   logic signed [31:0] z, logic last);
        proj_result_t r;
        logic signed [65:0] px, py, pw;
        bit vu, vv;
        px = row_sum(0, x, y, z);
        py = row_sum(1, x, y, z);
        pw = row_sum(2, x, y, z);
        r.u = '0;
        r.v = '0;
        r.vis = 1'b0;
        if (pw > 0) begin
            r.u = pixel_of(px, pw, img_w, vu);
            r.v = pixel_of(py, pw, img_h, vv);
            r.vis = vu && vv;
        end
        if (pw > 66'sd2147483647)
            r.depth = 32'sh7FFF_FFFF;
        else if (pw < -66'sd2147483648)
            r.depth = 32'sh8000_0000;
        else
            r.depth = pw[31:0];
        r.index = pt_count;
        r.sx = x;
        r.sy = y;
        r.sz = z;
        r.eoc = last;
        if (last)
            pt_count = '0;
        else if (pt_count < CNT_CAP)
            pt_count = pt_count + 1'b1;
        return r;
    endfunction

    // report one field mismatch
    task automatic cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (proj_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                proj_result_t e;
                e = proj_q.pop_front();
                cmp_field("visible", 64'(e.vis), 64'(m_visible));
                cmp_field("point_index", 64'(e.index), 64'(m_point_index));
                cmp_field("pixel_u", 64'(e.u), 64'(m_pixel_u));
                cmp_field("pixel_v", 64'(e.v), 64'(m_pixel_v));
                cmp_field("depth", 64'(e.depth), 64'(m_depth));
                cmp_field("source_x", 64'(e.sx), 64'(m_source_x));
                cmp_field("source_y", 64'(e.sy), 64'(m_source_y));
                cmp_field("source_z", 64'(e.sz), 64'(m_source_z));
                cmp_field("end_of_cloud", 64'(e.eoc), 64'(m_end_of_cloud));
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    int stall_mode;
    int mode_timer;
    int hold_cnt;
    always @(posedge aclk) begin
        if (mode_timer == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_timer <= $urandom_range(50, 300);
        end else begin
            mode_timer <= mode_timer - 1;
        end
        if (hold_cnt > 0) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req) begin
            m_ready  <= 1'b0;
            hold_cnt <= 300;
            hold_req = 0;
        end else begin
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 7) != 0);
                default: m_ready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // offer one word and wait for acceptance; valid stays up for the caller
    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic last);
        s_valid      <= 1'b1;
        s_point_x    <= x;
        s_point_y    <= y;
        s_point_z    <= z;
        s_last_point <= last;
        do @(posedge aclk); while (!s_ready);
        proj_q.insert(proj_q.size(), project_point(x, y, z, last));
    endtask

    // drop valid for a number of cycles
    task automatic pause_sender(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // burst-shaped sending used by the random tests
    task automatic send_bursty(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic last);
        send_point(x, y, z, last);
        burst_left--;
        if (burst_left <= 0) begin
            pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // wait until all results are back and the pipeline has drained
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (proj_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    // write all eight registers while idle
    task automatic load_config(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2,
                               logic [63:0] m3, logic [63:0] m4, logic [63:0] m5,
                               logic [15:0] w, logic [15:0] h);
        logic [63:0] vals [8];
        vals = '{m0, m1, m2, m3, m4, m5, {48'd0, w}, {48'd0, h}};
        wait_idle();
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= pcpc_pkg::cfg_reg_t'(i);
            cfg_wr_data <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < 6; i++) mat[i] = vals[i];
        img_w = w;
        img_h = h;
    endtask

    // standard pinhole: focal 500 px, center (320, 240), camera frame equals lidar frame
    function automatic logic [63:0] pack2(int c0, int c1);
        return {c1[31:0], c0[31:0]};
    endfunction

    task automatic load_pinhole(int tx, int ty, int tz, logic [15:0] w, logic [15:0] h);
        load_config(pack2(500 << 16, 0), pack2(320 << 16, tx),
                    pack2(0, 500 << 16), pack2(240 << 16, ty),
                    pack2(0, 0), pack2(1 << 16, tz), w, h);
    endtask

    // random point, mostly in front of a pinhole camera
    task automatic send_scene_point(logic last);
        logic signed [31:0] x, y, z;
        x = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        y = $signed($urandom_range(0, 30 << 16)) - (15 << 16);
        z = $urandom_range(0, 9) == 0 ? $signed($urandom_range(0, 1 << 17)) - (1 << 16)
                                      : $signed($urandom_range(1 << 14, 60 << 16));
        send_bursty(x, y, z, last);
    endtask

    // defaults after reset: zero matrix, nothing visible, counter counts
    task automatic test_reset_defaults();
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1'b0);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_point(-1, -1, -1, 1'b1);
        send_point(0, 0, 0, 1'b0);
    endtask

    // pinhole cases: center, edges, behind camera, zero depth, off image, huge quotient
    task automatic test_pinhole_cases();
        load_pinhole(0, 0, 0, 16'd640, 16'd480);
        send_point(0, 0, 10 << 16, 1'b0);
        send_point(-(32'sd64 << 16) / 5, -(32'sd48 << 16) / 5, 10 << 16, 1'b0);
        send_point(6 << 16, 0, 10 << 16, 1'b0);
        send_point((6 << 16) + 1, 0, 10 << 16, 1'b0);
        send_point(0, 48 << 14, 10 << 16, 1'b0);
        send_point(0, 0, -(5 << 16), 1'b0);
        send_point(0, 0, 0, 1'b0);
        send_point(-(30 << 16), 0, 1 << 16, 1'b0);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1'b0);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        send_point(1, 1, 1, 1'b0);
        send_point(0, 0, 32'sh7FFF_FFFF, 1'b1);
    endtask

    // image size extremes including zero
    task automatic test_image_bounds();
        load_pinhole(0, 0, 0, 16'd1, 16'd1);
        send_point(-(32'sd64 << 16) / 5, -(32'sd48 << 16) / 5, 10 << 16, 1'b0);
        send_point(0, 0, 10 << 16, 1'b0);
        load_pinhole(0, 0, 0, 16'hFFFF, 16'hFFFF);
        send_point(10 << 16, 10 << 16, 1 << 16, 1'b0);
        send_point(200 << 16, 200 << 16, 1 << 16, 1'b0);
        load_pinhole(0, 0, 0, 16'd0, 16'd0);
        send_point(0, 0, 10 << 16, 1'b1);
    endtask

    // extreme coefficients: row sums grow large and depth saturates
    task automatic test_extreme_matrix();
        load_config({2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h7FFF_FFFF}},
                    {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
                    16'hFFFF, 16'hFFFF);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        load_config({2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h8000_0000}},
                    {2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
                    16'd1, 16'd1);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_point(32'sh7FFF_FFFF, 0, -1, 1'b1);
    endtask

    // counter runs through a long cloud, then a last word clears it
    task automatic test_counter_clear();
        load_pinhole(0, 0, 0, 16'd640, 16'd480);
        for (int i = 0; i < 150; i++)
            send_point($urandom, $urandom, $urandom, 1'b0);
        send_point(0, 0, 1 << 16, 1'b1);
        send_point(0, 0, 1 << 16, 1'b0);
    endtask

    // random clouds through several settings; first phase with a long receiver hold-off
    task automatic test_random_clouds();
        logic [63:0] m [6];
        burst_left = $urandom_range(1, 40);
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_pinhole(0, 0, 0, 16'd640, 16'd480);
                1: load_pinhole($signed($urandom_range(0, 8 << 16)) - (4 << 16),
                                $signed($urandom_range(0, 8 << 16)) - (4 << 16),
                                $urandom_range(0, 2 << 16),
                                16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)));
                2: load_pinhole(0, 0, 0, 16'hFFFF, 16'd1);
                default: begin
                    for (int i = 0; i < 6; i++) m[i] = {$urandom, $urandom};
                    load_config(m[0], m[1], m[2], m[3], m[4], m[5],
                                16'($urandom), 16'($urandom));
                end
            endcase
            if (ph == 0) hold_req = 1;
            for (int i = 0; i < 270; i++) begin
                if (ph < 3 && $urandom_range(0, 4) != 0)
                    send_scene_point($urandom_range(0, 60) == 0);
                else
                    send_bursty($urandom, $urandom, $urandom, $urandom_range(0, 30) == 0);
            end
        end
    endtask

    initial begin
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= pcpc_pkg::REG_ROW0_01;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_point_x    <= '0;
        s_point_y    <= '0;
        s_point_z    <= '0;
        s_last_point <= 1'b0;
        m_ready      <= 1'b0;
        stall_mode   = 0;
        mode_timer   = 0;
        hold_cnt     = 0;
        hold_req     = 0;
        errors       = 0;
        cycles       = 0;
        for (int i = 0; i < 6; i++) mat[i] = '0;
        img_w    = 16'd640;
        img_h    = 16'd480;
        pt_count = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_pinhole_cases();
        test_image_bounds();
        test_extreme_matrix();
        test_random_clouds();
        test_counter_clear();

        wait_idle();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
